// ===== src/mtx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx_pkg
// shared types and codes for the mutex table unit
// ----------------------------------------------------------------------------
package mtx_pkg;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_LOCK   = 2'd1;
	localparam logic [1:0] CMD_UNLOCK = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INVALID    = 3'd1;
	localparam logic [2:0] ST_DEADLOCK   = 3'd2;
	localparam logic [2:0] ST_NOT_HOLDER = 3'd3;
	localparam logic [2:0] ST_NONE_FREE  = 3'd4;

	localparam logic [5:0] COUNT_MAX = 6'd63;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming item
		logic execute;  // evaluate and write back the tables
	} mtx_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic busy;
	} mtx_stat_t;

endpackage

// ===== src/mtx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx_ctrl
// controller: accepts an item, runs the update step, holds the result
// ----------------------------------------------------------------------------
module mtx_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mtx_pkg::mtx_stat_t stat,
	output mtx_pkg::mtx_cmd_t  cmd
);
	import mtx_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE) && !stat.busy;
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	// run the step once the result register is free or being emptied
	assign cmd.execute = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (cmd.capture) state_q <= S_EXEC;
				S_EXEC: if (cmd.execute) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.execute) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/mtx_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtx_dp
// datapath: mutex and task tables, decision logic, result register
// ----------------------------------------------------------------------------
module mtx_dp #(
	parameter int NUM_MUTEX = 32,
	parameter int NUM_TASKS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mtx_pkg::mtx_cmd_t  cmd,
	output mtx_pkg::mtx_stat_t stat,
	input  logic [1:0]         cmd_in,
	input  logic [4:0]         mutex_id,
	input  logic [5:0]         task_id,
	output logic [2:0]         status,
	output logic [4:0]         new_mutex,
	output logic               must_sleep,
	output logic               woken_valid,
	output logic [5:0]         woken_task,
	output logic               caller_top_prio
);
	import mtx_pkg::*;

	localparam int MW = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
	localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = $clog2(NUM_MUTEX + 1);

	logic [CW-1:0] created_q;
	logic [NUM_MUTEX-1:0] locked_q, qne_q;
	logic [NUM_TASKS-1:0][5:0] held_q;
	logic [5:0] holder_q [NUM_MUTEX];
	logic [5:0] head_q   [NUM_MUTEX];
	logic [5:0] tail_q   [NUM_MUTEX];
	logic [5:0] next_q   [NUM_TASKS];

	logic [1:0] c_q;
	logic [4:0] m_q;
	logic [TW-1:0] t_q;
	logic [5:0] cnt_t_q, cnt_h_q, nxt_q;

	// task number folded into the task range, one entry per task_id value
	logic [TW-1:0] tmod [64];
	for (genvar g = 0; g < 64; g++) begin : g_tmod
		assign tmod[g] = TW'(g % NUM_TASKS);
	end

	logic [MW-1:0] mi_in;
	logic [TW-1:0] t_in, h_in;

	assign mi_in = MW'(mutex_id);
	assign t_in  = tmod[task_id];
	assign h_in  = TW'(head_q[mi_in]);

	// item and the task table entries it needs are registered together
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			c_q     <= cmd_in;
			m_q     <= mutex_id;
			t_q     <= t_in;
			cnt_t_q <= held_q[t_in];
			cnt_h_q <= held_q[h_in];
			nxt_q   <= next_q[h_in];
		end
	end

	logic valid;
	logic [MW-1:0] mi;
	logic lk, qn, holder_eq, head_is_tail;
	logic [5:0] hold, head, tail;
	logic [TW-1:0] h;

	assign valid = (32'(m_q) < NUM_MUTEX) && (32'(m_q) < 32'(created_q));
	assign mi    = MW'(m_q);
	assign lk    = locked_q[mi];
	assign qn    = qne_q[mi];
	assign hold  = holder_q[mi];
	assign head  = head_q[mi];
	assign tail  = tail_q[mi];
	assign holder_eq = (hold == 6'(t_q));
	assign h = TW'(head);
	assign head_is_tail = (6'(h) == tail);
	assign stat.busy = 1'b0;

	logic [2:0] st_d;
	logic do_create, do_grant, do_queue, do_free, do_pass;

	always_comb begin
		st_d = ST_OK;
		do_create = 1'b0; do_grant = 1'b0; do_queue = 1'b0;
		do_free = 1'b0; do_pass = 1'b0;
		case (c_q)
			CMD_CREATE: begin
				if (32'(created_q) < NUM_MUTEX) do_create = 1'b1;
				else st_d = ST_NONE_FREE;
			end
			CMD_LOCK: begin
				if (!valid) st_d = ST_INVALID;
				else if (lk && holder_eq) st_d = ST_DEADLOCK;
				else if (!lk) do_grant = 1'b1;
				else do_queue = 1'b1;
			end
			CMD_UNLOCK: begin
				if (!valid) st_d = ST_INVALID;
				else if (!lk || !holder_eq) st_d = ST_NOT_HOLDER;
				else if (!qn) do_free = 1'b1;
				else do_pass = 1'b1;
			end
			default: st_d = ST_INVALID;
		endcase
	end

	// caller count after this command; the woken task can be the caller
	// itself when it is also queued on this mutex
	logic [5:0] cnt_t, cnt_t_d, cnt_h, cnt_h_d;
	assign cnt_t = cnt_t_q;
	assign cnt_h = cnt_h_q;
	always_comb begin
		cnt_h_d = (cnt_h < COUNT_MAX) ? cnt_h + 6'd1 : cnt_h;
		cnt_t_d = cnt_t;
		if (do_grant && cnt_t < COUNT_MAX) cnt_t_d = cnt_t + 6'd1;
		if (do_free || do_pass) begin
			// a woken task equal to the caller is raised first, then lowered
			if (do_pass && h == t_q) cnt_t_d = (cnt_h_d > 6'd0) ? cnt_h_d - 6'd1 : 6'd0;
			else cnt_t_d = (cnt_t > 6'd0) ? cnt_t - 6'd1 : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= '0;
			locked_q  <= '0;
			qne_q     <= '0;
			held_q    <= '0;
		end else if (cmd.execute) begin
			if (do_create) created_q <= created_q + CW'(1);
			if (do_grant) locked_q[mi] <= 1'b1;
			if (do_free) locked_q[mi] <= 1'b0;
			if (do_queue) qne_q[mi] <= 1'b1;
			if (do_pass && head_is_tail) qne_q[mi] <= 1'b0;
			if (do_pass && h != t_q) held_q[h] <= cnt_h_d;
			held_q[t_q] <= cnt_t_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			if (do_grant) holder_q[mi] <= 6'(t_q);
			if (do_pass) holder_q[mi] <= 6'(h);
			if (do_queue) begin
				if (qn) next_q[TW'(tail)] <= 6'(t_q);
				else head_q[mi] <= 6'(t_q);
				tail_q[mi] <= 6'(t_q);
			end
			if (do_pass && !head_is_tail) head_q[mi] <= nxt_q;
			status          <= st_d;
			new_mutex       <= do_create ? 5'(created_q) : 5'd0;
			must_sleep      <= do_queue;
			woken_valid     <= do_pass;
			woken_task      <= do_pass ? 6'(h) : 6'd0;
			caller_top_prio <= (cnt_t_d != 6'd0);
		end
	end

endmodule

// ===== src/mutex_table_with_wait_queues_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_table_with_wait_queues_unit
// lock manager with per-mutex fifo wait queues
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command item (create, lock, unlock) from a task
//   m_axis returns exactly one result item per command, in order
//   at the edge that takes an item the task table entries it needs are
//   read into registers; at the edge that executes it, once the result
//   register is free or being emptied, the decision is made, the tables
//   are written back and the result is registered
//   no new item is taken while an item waits to execute, since each
//   item does a read-modify-write of the tables
//   reset clears the created count, lock and queue flags and hold counts;
//   holder, head, tail and link entries are only meaningful once written
//   while the receiver stalls the result holds; one further item may be
//   taken and waits, and no other item is taken until the result leaves
// ----------------------------------------------------------------------------
module mutex_table_with_wait_queues_unit #(
	parameter int NUM_MUTEX = 32,
	parameter int NUM_TASKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cmd[1:0], mutex_id[6:2], task_id[12:7]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[2:0], new_mutex[7:3], must_sleep[8],
	                                   // woken_valid[9], woken_task[15:10],
	                                   // caller_top_prio[16]
);
	import mtx_pkg::*;

	mtx_cmd_t  cmd;
	mtx_stat_t stat;
	logic [2:0] status;
	logic [4:0] new_mutex;
	logic must_sleep, woken_valid, caller_top_prio;
	logic [5:0] woken_task;

	// sequencing
	mtx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.stat(stat), .cmd(cmd)
	);

	// tables and decision
	mtx_dp #(.NUM_MUTEX(NUM_MUTEX), .NUM_TASKS(NUM_TASKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cmd_in(s_axis_tdata[1:0]), .mutex_id(s_axis_tdata[6:2]),
		.task_id(s_axis_tdata[12:7]),
		.status(status), .new_mutex(new_mutex), .must_sleep(must_sleep),
		.woken_valid(woken_valid), .woken_task(woken_task),
		.caller_top_prio(caller_top_prio)
	);

	assign m_axis_tdata = {7'd0, caller_top_prio, woken_task, woken_valid,
		must_sleep, new_mutex, status};

	// a stalled result stays on offer unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped or changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
		else $error("result not presented");

	// a sleeping caller never also wakes a task
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(must_sleep && woken_valid)) else $error("sleep and wake together");

endmodule
